// ===== sv/lcc_pkg.sv =====
// Shared types, constants and small functions for the Luhn card number check.
// Used by every module of the block; depends on nothing else.

package lcc_pkg;

  localparam int CARD_W         = 54;
  localparam int CLASS_W        = 2;
  localparam int MAX_DIGITS_DEF = 16;
  localparam int CONV_DIGITS    = 17;
  localparam int BCD_W          = 4 * CONV_DIGITS;
  localparam int SUM_W          = 8;
  localparam int LUHN_MOD       = 10;

  typedef enum logic [CLASS_W-1:0] {
    CLASS_INVALID    = 2'd0,
    CLASS_VISA       = 2'd1,
    CLASS_AMEX       = 2'd2,
    CLASS_MASTERCARD = 2'd3
  } card_class_t;

  typedef struct packed {
    logic        in_range;
    card_class_t pre_class;
  } lcc_info_t;

  localparam logic [CARD_W-1:0] VISA13_LO = 54'd4000000000000;
  localparam logic [CARD_W-1:0] VISA13_HI = 54'd4999999999999;
  localparam logic [CARD_W-1:0] VISA16_LO = 54'd4000000000000000;
  localparam logic [CARD_W-1:0] VISA16_HI = 54'd4999999999999999;
  localparam logic [CARD_W-1:0] AMEX34_LO = 54'd340000000000000;
  localparam logic [CARD_W-1:0] AMEX34_HI = 54'd349999999999999;
  localparam logic [CARD_W-1:0] AMEX37_LO = 54'd370000000000000;
  localparam logic [CARD_W-1:0] AMEX37_HI = 54'd379999999999999;
  localparam logic [CARD_W-1:0] MC_LO     = 54'd5100000000000000;
  localparam logic [CARD_W-1:0] MC_HI     = 54'd5599999999999999;

  function automatic logic [63:0] digit_limit(input int digits);
    logic [63:0] lim;
    lim = 64'd1;
    for (int k = 0; k < digits; k++) begin
      lim = lim * 64'd10;
    end
    return lim - 64'd1;
  endfunction

  function automatic logic [3:0] dd_adjust(input logic [3:0] d);
    return (d >= 4'd5) ? d + 4'd3 : d;
  endfunction

  function automatic logic [3:0] luhn_weigh(input logic [3:0] d, input logic dbl);
    logic [3:0] w;
    if (!dbl) begin
      w = d;
    end else begin
      case (d)
        4'd0:    w = 4'd0;
        4'd1:    w = 4'd2;
        4'd2:    w = 4'd4;
        4'd3:    w = 4'd6;
        4'd4:    w = 4'd8;
        4'd5:    w = 4'd1;
        4'd6:    w = 4'd3;
        4'd7:    w = 4'd5;
        4'd8:    w = 4'd7;
        4'd9:    w = 4'd9;
        default: w = 4'd0;
      endcase
    end
    return w;
  endfunction

endpackage

// ===== sv/lcc_cell.sv =====
// One cell of the binary-to-decimal chain: adjusts the decimal digits and
// shifts in the next binary bit. Depends on lcc_pkg.

module lcc_cell (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     en,
  input  logic                     v_i,
  input  logic [lcc_pkg::BCD_W-1:0]  bcd_i,
  input  logic [lcc_pkg::CARD_W-1:0] bin_i,
  input  lcc_pkg::lcc_info_t       info_i,
  output logic                     v_o,
  output logic [lcc_pkg::BCD_W-1:0]  bcd_o,
  output logic [lcc_pkg::CARD_W-1:0] bin_o,
  output lcc_pkg::lcc_info_t       info_o
);
  import lcc_pkg::*;

  logic              v_r;
  logic [BCD_W-1:0]  bcd_r, bcd_nxt, bcd_adj;
  logic [CARD_W-1:0] bin_r, bin_nxt;
  lcc_info_t         info_r;

  always_comb begin
    for (int i = 0; i < CONV_DIGITS; i++) begin
      bcd_adj[4*i +: 4] = dd_adjust(bcd_i[4*i +: 4]);
    end
    bcd_nxt = {bcd_adj[BCD_W-2:0], bin_i[CARD_W-1]};
    bin_nxt = {bin_i[CARD_W-2:0], 1'b0};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= v_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      bcd_r  <= bcd_nxt;
      bin_r  <= bin_nxt;
      info_r <= info_i;
    end
  end

  assign v_o    = v_r;
  assign bcd_o  = bcd_r;
  assign bin_o  = bin_r;
  assign info_o = info_r;

endmodule

// ===== sv/lcc_sum.sv =====
// Two-stage Luhn sum over the decimal digits: group sums, then the total and
// its test for a multiple of ten. Depends on lcc_pkg.

module lcc_sum #(
  parameter int MAX_DIGITS = lcc_pkg::MAX_DIGITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  logic                    v_i,
  input  logic [lcc_pkg::BCD_W-1:0] bcd_i,
  input  lcc_pkg::lcc_info_t      info_i,
  output logic                    v_o,
  output logic                    ok_o,
  output lcc_pkg::lcc_info_t      info_o
);
  import lcc_pkg::*;

  localparam int NG       = (MAX_DIGITS + 3) / 4;
  localparam int DPAD     = 4 * NG;
  localparam int PW       = (DPAD > CONV_DIGITS) ? DPAD : CONV_DIGITS;
  localparam int MAX_MULT = (9 * MAX_DIGITS) / LUHN_MOD;

  logic [4*PW-1:0] bcd_pad;
  logic [SUM_W-1:0] grp_nxt [NG];
  logic [SUM_W-1:0] grp_r   [NG];
  logic             v1_r, v2_r;
  lcc_info_t        info1_r, info2_r;
  logic [SUM_W-1:0] total;
  logic             ok_nxt, ok2_r;

  assign bcd_pad = (4*PW)'(bcd_i);

  always_comb begin
    for (int g = 0; g < NG; g++) begin
      grp_nxt[g] = '0;
      for (int j = 0; j < 4; j++) begin
        if (4*g + j < MAX_DIGITS) begin
          grp_nxt[g] = grp_nxt[g] + SUM_W'(luhn_weigh(bcd_pad[4*(4*g+j) +: 4], j[0]));
        end
      end
    end
  end

  always_comb begin
    total = '0;
    for (int g = 0; g < NG; g++) begin
      total = total + grp_r[g];
    end
    ok_nxt = 1'b0;
    for (int k = 0; k <= MAX_MULT; k++) begin
      if (total == SUM_W'(k * LUHN_MOD)) begin
        ok_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v1_r <= v_i;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      grp_r   <= grp_nxt;
      info1_r <= info_i;
      ok2_r   <= ok_nxt;
      info2_r <= info1_r;
    end
  end

  assign v_o    = v2_r;
  assign ok_o   = ok2_r;
  assign info_o = info2_r;

endmodule

// ===== sv/luhn_card_number_check_top.sv =====
// Top level of the Luhn card number check: input stage, decimal conversion
// chain of lcc_cell, lcc_sum and the output register. Depends on lcc_pkg.
//
// Usage: a card number enters on in_card_number with in_valid/in_ready; one
// result beat per number leaves on out_card_class and out_luhn_ok with
// out_valid/out_ready. Numbers are independent and carry no state.
// On its way to the output a number passes one input stage, 54 conversion
// cells (one per input bit), two sum stages and the output register.
// Throughput: one number per cycle while in_ready is high, set by the
// conversion chain, which holds one number in each cell.
// When the receiver stalls, the result holds on the output and the chain keeps
// accepting while its last stage is empty; once it is full, in_ready drops and
// the whole chain holds.
// Reset (rst_n low at a clock edge) empties every stage and the output
// register; no number in flight survives it.

module luhn_card_number_check_top #(
  parameter int MAX_DIGITS = lcc_pkg::MAX_DIGITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [lcc_pkg::CARD_W-1:0]  in_card_number,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [lcc_pkg::CLASS_W-1:0] out_card_class,
  output logic                      out_luhn_ok
);
  import lcc_pkg::*;

  localparam logic [63:0] LIMIT = digit_limit(MAX_DIGITS);

  logic        en, ob_free;
  lcc_info_t   info_nxt;
  logic        s0_v_r;
  logic [CARD_W-1:0] s0_bin_r;
  lcc_info_t   s0_info_r;

  logic              v_c    [CARD_W+1];
  logic [BCD_W-1:0]  bcd_c  [CARD_W+1];
  logic [CARD_W-1:0] bin_c  [CARD_W+1];
  lcc_info_t         info_c [CARD_W+1];

  logic        sv_last, s_ok;
  lcc_info_t   s_info;
  logic        out_valid_r, out_luhn_ok_r, out_luhn_ok_nxt;
  card_class_t out_class_r, out_class_nxt;

  always_comb begin
    info_nxt.in_range  = (in_card_number != '0) && (64'(in_card_number) <= LIMIT);
    info_nxt.pre_class = CLASS_INVALID;
    if ((in_card_number >= VISA13_LO && in_card_number <= VISA13_HI) ||
        (in_card_number >= VISA16_LO && in_card_number <= VISA16_HI)) begin
      info_nxt.pre_class = CLASS_VISA;
    end else if ((in_card_number >= AMEX34_LO && in_card_number <= AMEX34_HI) ||
                 (in_card_number >= AMEX37_LO && in_card_number <= AMEX37_HI)) begin
      info_nxt.pre_class = CLASS_AMEX;
    end else if (in_card_number >= MC_LO && in_card_number <= MC_HI) begin
      info_nxt.pre_class = CLASS_MASTERCARD;
    end
  end

  assign ob_free  = !out_valid_r || out_ready;
  assign en       = !sv_last || ob_free;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
    end else if (en) begin
      s0_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_bin_r  <= in_card_number;
      s0_info_r <= info_nxt;
    end
  end

  assign v_c[0]    = s0_v_r;
  assign bcd_c[0]  = '0;
  assign bin_c[0]  = s0_bin_r;
  assign info_c[0] = s0_info_r;

  for (genvar k = 0; k < CARD_W; k++) begin : g_cell
    lcc_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .v_i    (v_c[k]),
      .bcd_i  (bcd_c[k]),
      .bin_i  (bin_c[k]),
      .info_i (info_c[k]),
      .v_o    (v_c[k+1]),
      .bcd_o  (bcd_c[k+1]),
      .bin_o  (bin_c[k+1]),
      .info_o (info_c[k+1])
    );
  end

  lcc_sum #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_sum (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .v_i    (v_c[CARD_W]),
    .bcd_i  (bcd_c[CARD_W]),
    .info_i (info_c[CARD_W]),
    .v_o    (sv_last),
    .ok_o   (s_ok),
    .info_o (s_info)
  );

  always_comb begin
    out_luhn_ok_nxt = s_info.in_range && s_ok;
    out_class_nxt   = out_luhn_ok_nxt ? s_info.pre_class : CLASS_INVALID;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ob_free) begin
      out_valid_r <= sv_last;
    end
  end

  always_ff @(posedge clk) begin
    if (ob_free && sv_last) begin
      out_luhn_ok_r <= out_luhn_ok_nxt;
      out_class_r   <= out_class_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_luhn_ok    = out_luhn_ok_r;
  assign out_card_class = CLASS_W'(out_class_r);

endmodule

// ===== sv/lcc_checker.sv =====
// Port-level checker for the Luhn card number check and its bind to the top
// level. Depends on lcc_pkg and luhn_card_number_check_top.

module lcc_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic [lcc_pkg::CARD_W-1:0]  in_card_number,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [lcc_pkg::CLASS_W-1:0] out_card_class,
  input logic                      out_luhn_ok
);
  import lcc_pkg::*;

  // A waiting input beat stays offered with the same card number.
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_card_number))
    else $error("input beat changed while waiting");

  // A stalled result beat keeps its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_card_class) && $stable(out_luhn_ok))
    else $error("result beat changed while stalled");

  // A card class is only reported for a number that passed the check.
  a_class_needs_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_card_class != CLASS_W'(CLASS_INVALID) |-> out_luhn_ok)
    else $error("card class given without a passing Luhn sum");

  // With the output register empty the block always takes a new beat.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled while the output register is empty");

  // Reset empties the output register.
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result beat present right after reset");

endmodule

bind luhn_card_number_check_top lcc_checker u_lcc_checker (.*);
